// ===== hw/rtl/bde_pkg.sv =====
// Shared types and constants for the bounded deque engine.
`timescale 1ns / 1ps

package bde_pkg;

  // Payload field widths
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;
  localparam int TDATA_W  = 40;

  // Default sizing handed to the top level
  localparam int DEF_DEPTH     = 64;
  localparam int DEF_WORD_BITS = 32;

  // Request codes carried on s_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_DROP_FRONT = 3'd2,
    REQ_DROP_BACK  = 3'd3,
    REQ_DUMP       = 3'd4
  } bde_req_t;

  // Result status carried on m_tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_UNDER = 2'd2,
    STAT_EMPTY = 2'd3
  } bde_stat_t;

  // Operation issued by the controller for an accepted item
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_DROP_FRONT,
    OP_DROP_BACK,
    OP_DUMP_EMPTY,
    OP_DUMP_START
  } bde_op_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_DUMP
  } bde_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    bde_op_t op;
    logic    issue;
    logic    load;
  } bde_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_valid;
    logic pend;
    logic rem_zero;
    logic count_zero;
  } bde_status_t;

endpackage

// ===== hw/rtl/bde_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bde_ctrl.sv =====
// Controller state machine for the bounded deque engine.
`timescale 1ns / 1ps

module bde_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [bde_pkg::REQ_W-1:0]  req_type,
  input  logic                       m_tready,
  input  bde_pkg::bde_status_t       stat,
  output bde_pkg::bde_cmd_t          cmd
);

  bde_pkg::bde_state_t state, state_next;
  logic                out_free;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bde_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !stat.out_valid || m_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd.op     = bde_pkg::OP_NONE;
    cmd.issue  = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      bde_pkg::S_IDLE: begin
        s_tready = out_free;
        if (s_tvalid && out_free) begin
          unique case (req_type)
            bde_pkg::REQ_PUSH_FRONT: cmd.op = bde_pkg::OP_PUSH_FRONT;
            bde_pkg::REQ_PUSH_BACK:  cmd.op = bde_pkg::OP_PUSH_BACK;
            bde_pkg::REQ_DROP_FRONT: cmd.op = bde_pkg::OP_DROP_FRONT;
            bde_pkg::REQ_DROP_BACK:  cmd.op = bde_pkg::OP_DROP_BACK;
            bde_pkg::REQ_DUMP: begin
              if (stat.count_zero) begin
                cmd.op = bde_pkg::OP_DUMP_EMPTY;
              end else begin
                cmd.op     = bde_pkg::OP_DUMP_START;
                state_next = bde_pkg::S_DUMP;
              end
            end
            default: cmd.op = bde_pkg::OP_NONE;
          endcase
        end
      end
      bde_pkg::S_DUMP: begin
        // Move read data out, refill the read stage behind it
        cmd.load  = stat.pend && out_free;
        cmd.issue = !stat.rem_zero && (!stat.pend || cmd.load);
        if (stat.rem_zero && (!stat.pend || cmd.load)) begin
          state_next = bde_pkg::S_IDLE;
        end
      end
      default: state_next = bde_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/bde_datapath.sv =====
// Datapath: pointers, fill count, ring store and output register.
`timescale 1ns / 1ps

module bde_datapath #(
  parameter int DEPTH     = bde_pkg::DEF_DEPTH,
  parameter int WORD_BITS = bde_pkg::DEF_WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bde_pkg::bde_cmd_t            cmd,
  input  logic [bde_pkg::WORD_W-1:0]   data_word,
  input  logic [bde_pkg::COUNT_W-1:0]  drop_count,
  input  logic                         m_tready,
  output bde_pkg::bde_status_t         stat,
  output logic                         out_valid,
  output logic [bde_pkg::WORD_W-1:0]   out_word,
  output logic                         out_last,
  output bde_pkg::bde_stat_t           out_status,
  output logic [bde_pkg::COUNT_W-1:0]  out_fill
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0] DEPTH_S = (PTR_W + 1)'(DEPTH);

  logic [PTR_W-1:0]     front, back, rd_ptr;
  logic [PTR_W-1:0]     front_next, back_next;
  logic [CNT_W-1:0]     count, count_next, rem, n_eff;
  logic [PTR_W:0]       n_mod;
  logic                 pend, pend_last, full, over, result;
  logic [PTR_W-1:0]     front_dec1, back_inc1, front_incn, back_decn, rd_inc1;
  logic [WORD_BITS-1:0] rdata;
  logic                 we;
  logic [PTR_W-1:0]     waddr;
  bde_pkg::bde_stat_t   res_status;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] s);
    wrap = (s >= DEPTH_S) ? PTR_W'(s - DEPTH_S) : PTR_W'(s);
  endfunction

  // Clamp the drop amount to the fill
  assign full  = (count == CNT_W'(DEPTH));
  assign over  = (drop_count > bde_pkg::COUNT_W'(count));
  assign n_eff = over ? count : CNT_W'(drop_count);
  assign n_mod = (n_eff == CNT_W'(DEPTH)) ? '0 : (PTR_W + 1)'(n_eff);

  // Pointer moves
  assign front_dec1 = wrap({1'b0, front} + DEPTH_S - (PTR_W + 1)'(1));
  assign back_inc1  = wrap({1'b0, back} + (PTR_W + 1)'(1));
  assign front_incn = wrap({1'b0, front} + (PTR_W + 1)'(n_eff));
  assign back_decn  = wrap({1'b0, back} + DEPTH_S - n_mod);
  assign rd_inc1    = wrap({1'b0, rd_ptr} + (PTR_W + 1)'(1));

  // Next pointers, fill and result status
  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    res_status = bde_pkg::STAT_OK;
    result     = 1'b1;
    case (cmd.op)
      bde_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res_status = bde_pkg::STAT_FULL;
        end else begin
          front_next = front_dec1;
          count_next = count + CNT_W'(1);
        end
      end
      bde_pkg::OP_PUSH_BACK: begin
        if (full) begin
          res_status = bde_pkg::STAT_FULL;
        end else begin
          back_next  = back_inc1;
          count_next = count + CNT_W'(1);
        end
      end
      bde_pkg::OP_DROP_FRONT: begin
        front_next = front_incn;
        count_next = count - n_eff;
        res_status = over ? bde_pkg::STAT_UNDER : bde_pkg::STAT_OK;
      end
      bde_pkg::OP_DROP_BACK: begin
        back_next  = back_decn;
        count_next = count - n_eff;
        res_status = over ? bde_pkg::STAT_UNDER : bde_pkg::STAT_OK;
      end
      bde_pkg::OP_DUMP_EMPTY: res_status = bde_pkg::STAT_EMPTY;
      default: result = 1'b0;
    endcase
  end

  // Ring store write
  assign we    = !full && (cmd.op == bde_pkg::OP_PUSH_FRONT || cmd.op == bde_pkg::OP_PUSH_BACK);
  assign waddr = (cmd.op == bde_pkg::OP_PUSH_FRONT) ? front_dec1 : back;

  bde_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (WORD_BITS'($unsigned(data_word))),
    .re    (cmd.issue),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      count     <= '0;
      rd_ptr    <= '0;
      rem       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
      if (cmd.op == bde_pkg::OP_DUMP_START) begin
        rd_ptr <= front;
        rem    <= count;
      end
      // Advance the dump read stage
      if (cmd.issue) begin
        rd_ptr <= rd_inc1;
        rem    <= rem - CNT_W'(1);
        pend   <= 1'b1;
      end else if (cmd.load) begin
        pend <= 1'b0;
      end
      // Output register occupancy
      if (result || cmd.load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pend_last <= (rem == CNT_W'(1));
    end
    if (result) begin
      out_word   <= '0;
      out_last   <= 1'b1;
      out_status <= res_status;
      out_fill   <= bde_pkg::COUNT_W'(count_next);
    end else if (cmd.load) begin
      out_word   <= bde_pkg::WORD_W'($unsigned(rdata));
      out_last   <= pend_last;
      out_status <= bde_pkg::STAT_OK;
      out_fill   <= bde_pkg::COUNT_W'(count);
    end
  end

  assign stat.out_valid  = out_valid;
  assign stat.pend       = pend;
  assign stat.rem_zero   = (rem == '0);
  assign stat.count_zero = (count == '0);

endmodule

// ===== hw/rtl/bounded_deque_engine_core.sv =====
// Top level of the bounded deque engine: controller plus datapath.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata {drop_count, data_word}, s_tuser req_type
//  m_      | out | m_tvalid/m_tready | m_tdata {fill_level, out_word}, m_tlast, m_tuser status
//
// Push, drop and dump of an empty queue each give one result item. A dump of n words
// gives n items: after the accepting cycle each word is read in turn through the single
// registered read port of the ring store and then moved to the output register.
// The next item is taken once the dump's last read has moved to the output register.
// A stalled m_ side holds the output register and pauses the dump reads.
// Reset is synchronous; the ring store needs no clearing pass.
`timescale 1ns / 1ps

module bounded_deque_engine_core #(
  parameter int DEPTH     = bde_pkg::DEF_DEPTH,
  parameter int WORD_BITS = bde_pkg::DEF_WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [31:0] data_word, [38:32] drop_count, [39] zero
  input  logic [bde_pkg::TDATA_W-1:0]  s_tdata,
  // [2:0] req_type
  input  logic [bde_pkg::REQ_W-1:0]    s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [31:0] out_word, [38:32] fill_level, [39] zero
  output logic [bde_pkg::TDATA_W-1:0]  m_tdata,
  output logic                         m_tlast,
  // [1:0] status
  output logic [bde_pkg::STAT_W-1:0]   m_tuser
);

  bde_pkg::bde_cmd_t             cmd;
  bde_pkg::bde_status_t          dp_stat;
  logic [bde_pkg::WORD_W-1:0]    out_word;
  logic [bde_pkg::COUNT_W-1:0]   out_fill;
  bde_pkg::bde_stat_t            out_status;

  bde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .m_tready (m_tready),
    .stat     (dp_stat),
    .cmd      (cmd)
  );

  bde_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_word  (s_tdata[31:0]),
    .drop_count (s_tdata[38:32]),
    .m_tready   (m_tready),
    .stat       (dp_stat),
    .out_valid  (m_tvalid),
    .out_word   (out_word),
    .out_last   (m_tlast),
    .out_status (out_status),
    .out_fill   (out_fill)
  );

  // Pack the result item
  assign m_tdata = {1'b0, out_fill, out_word};
  assign m_tuser = out_status;

  // Fill reported never exceeds the ring size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[38:32] <= bde_pkg::COUNT_W'(DEPTH)))
    else $error("fill level above depth");

  // No new item while dump data is still in the read stage
  a_no_accept_pend: assert property (@(posedge clk) disable iff (rst)
    dp_stat.pend |-> !s_tready)
    else $error("item accepted during dump");

  // An empty dump result carries a zero word and zero fill
  a_empty_dump: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == bde_pkg::STAT_EMPTY) |->
      (m_tdata[31:0] == '0 && m_tdata[38:32] == '0 && m_tlast))
    else $error("bad empty dump result");

  // A dump read is issued only with room behind it in the output path
  a_issue_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && dp_stat.pend) |-> cmd.load)
    else $error("dump read overwrote pending data");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the bounded deque engine core.
`timescale 1ns / 1ps

module tb;
  import bde_pkg::*;

  localparam int QUEUE_DEPTH = DEF_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLDOFF_CYCLES = 220;
  localparam int IDLE_PCT = 35;
  // Request codes the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST = 3'd7;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic last;
    bde_stat_t status;
    logic [COUNT_W-1:0] fill;
  } deque_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic [REQ_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic [STAT_W-1:0] m_tuser;

  // Shadow deque contents, front at index 0
  logic [WORD_W-1:0] shadow_words[$];
  deque_result_t awaited_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int holdoff_left = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;

  bounded_deque_engine_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Queue one expected result
  task automatic await_result(input logic [WORD_W-1:0] word, input logic last,
                              input bde_stat_t status);
    deque_result_t r;
    r.word = word;
    r.last = last;
    r.status = status;
    r.fill = COUNT_W'(shadow_words.size());
    awaited_results.push_back(r);
  endtask

  // Update the shadow deque for an accepted request and queue its results
  task automatic apply_request(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] word,
                               input logic [COUNT_W-1:0] cnt);
    int n;
    bde_stat_t st;
    n = cnt;
    st = STAT_OK;
    case (code)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_words.size() >= QUEUE_DEPTH) begin
          st = STAT_FULL;
        end else if (code == REQ_PUSH_FRONT) begin
          shadow_words.push_front(word);
        end else begin
          shadow_words.push_back(word);
        end
        await_result('0, 1'b1, st);
      end
      REQ_DROP_FRONT, REQ_DROP_BACK: begin
        if (n > shadow_words.size()) begin
          n = shadow_words.size();
          st = STAT_UNDER;
        end
        repeat (n) begin
          if (code == REQ_DROP_FRONT) void'(shadow_words.pop_front());
          else void'(shadow_words.pop_back());
        end
        await_result('0, 1'b1, st);
      end
      REQ_DUMP: begin
        if (shadow_words.size() == 0) begin
          await_result('0, 1'b1, STAT_EMPTY);
        end else begin
          foreach (shadow_words[i])
            await_result(shadow_words[i], i == shadow_words.size() - 1, STAT_OK);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request and hold it until the block takes it
  task automatic offer_request(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] word,
                               input logic [COUNT_W-1:0] cnt);
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= code;
    s_tdata <= {1'b0, cnt, word};
    do @(posedge clk); while (!s_tready);
    apply_request(code, word, cnt);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly short drops, now and then up to the whole depth
  function automatic logic [COUNT_W-1:0] pick_drop_count();
    if ($urandom_range(9) < 7) return COUNT_W'($urandom_range(3));
    return COUNT_W'($urandom_range(QUEUE_DEPTH));
  endfunction

  // Field extremes, each operation and the corner cases on a short queue
  task automatic test_boundaries();
    offer_request(REQ_DUMP, pick_word(), '0);
    offer_request(REQ_DROP_FRONT, pick_word(), 7'd0);
    offer_request(REQ_DROP_BACK, pick_word(), 7'd5);
    offer_request(REQ_PUSH_BACK, 32'h7fff_ffff, 7'h7f >> 1);
    offer_request(REQ_PUSH_FRONT, 32'h8000_0000, 7'd64);
    offer_request(REQ_PUSH_BACK, 32'hffff_ffff, '0);
    offer_request(REQ_PUSH_FRONT, 32'h0000_0000, 7'd64);
    offer_request(REQ_DUMP, 32'h5555_5555, '0);
    offer_request(REQ_DROP_FRONT, 32'haaaa_aaaa, 7'd1);
    offer_request(REQ_DROP_BACK, pick_word(), 7'd1);
    offer_request(REQ_DUMP, pick_word(), '0);
    offer_request(REQ_DROP_FRONT, pick_word(), 7'd0);
    offer_request(REQ_DROP_BACK, pick_word(), 7'd64);
    for (logic [REQ_W-1:0] c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST && c != 0; c++)
      offer_request(c, pick_word(), pick_drop_count());
    offer_request(REQ_DUMP, pick_word(), '0);
    offer_request(REQ_PUSH_FRONT, pick_word(), '0);
    offer_request(REQ_DROP_FRONT, pick_word(), 7'd3);
  endtask

  // Stall the receiver at the start of a run of pushes that fills the queue, then refuse, dump and drain exactly
  task automatic test_full_under_backpressure();
    drain_results();
    holdoff_left = HOLDOFF_CYCLES;
    repeat (QUEUE_DEPTH + 2)
      offer_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_word(),
                    pick_drop_count());
    offer_request(REQ_DUMP, pick_word(), '0);
    offer_request(REQ_DROP_FRONT, pick_word(), 7'(QUEUE_DEPTH));
    offer_request(REQ_DUMP, pick_word(), '0);
  endtask

  // Random requests with weights in percent for pushes and drops; rest dumps and noise
  task automatic test_random_mix(input int items, input int push_pct, input int drop_pct);
    int roll;
    logic [REQ_W-1:0] code;
    repeat (items) begin
      roll = $urandom_range(99);
      if (roll < push_pct)
        code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else if (roll < push_pct + drop_pct)
        code = $urandom_range(1) ? REQ_DROP_BACK : REQ_DROP_FRONT;
      else if (roll < 96)
        code = REQ_DUMP;
      else
        code = REQ_W'(REQ_UNUSED_FIRST
                      + $urandom_range(REQ_UNUSED_LAST - REQ_UNUSED_FIRST));
      offer_request(code, pick_word(), pick_drop_count());
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off when requested
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      m_tready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      m_tready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: out_word %h", m_tdata[WORD_W-1:0]);
        error_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (m_tdata[WORD_W-1:0] !== exp_r.word) begin
          $error("out_word expected %h actual %h", exp_r.word, m_tdata[WORD_W-1:0]);
          error_count++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("is_last expected %0d actual %0d", exp_r.last, m_tlast);
          error_count++;
        end
        if (m_tuser !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, m_tuser);
          error_count++;
        end
        if (m_tdata[WORD_W+COUNT_W-1:WORD_W] !== exp_r.fill) begin
          $error("fill_level expected %0d actual %0d", exp_r.fill,
                 m_tdata[WORD_W+COUNT_W-1:WORD_W]);
          error_count++;
        end
      end
    end
  end

  // Bound the run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_boundaries();
    test_full_under_backpressure();
    test_random_mix(45, 75, 10);
    // Long stretch with both sides streaming flat out
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random_mix(60, 45, 35);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    drain_results();
    test_random_mix(40, 30, 55);
    test_random_mix(40, 50, 35);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
